// File: src/qacs_pkg.sv
package qacs_pkg;

    // Characters with a meaning outside quotes
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_PIPE   = 8'h7C;  // '|'
    localparam logic [7:0] CH_AMP    = 8'h26;  // '&'
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\'
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote

    // Results one byte can cause, and the result queue that absorbs them
    localparam int MAX_RES   = 3;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] seg_byte;
        logic       is_boundary;
        logic       last;
    } t_result;

endpackage

// File: src/quote_aware_command_splitter_core.sv
// Timing: the first result of an accepted byte is offered in the cycle after acceptance when
//   the result queue is empty; otherwise it waits behind the results already queued.
// Throughput: one command byte per cycle while at most five results are queued; each byte
//   causes zero to three results, which leave through an 8-entry result queue at one per
//   cycle, so the output port sets the long-run rate if bytes average over one result.
// Reset: synchronous, active low; clears quote, hold and escape state and empties the queue.
module quote_aware_command_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] cmd_byte
    input  logic       i_s_axis_tlast,   // end_of_command
    // result stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] seg_byte (zero on boundaries)
    output logic       o_m_axis_tuser,   // [0] is_boundary
    output logic       o_m_axis_tlast    // last result of the final command byte
);
    import qacs_pkg::*;

    // Parser state
    logic       r_sq, r_dq;        // single / double quote open
    logic       r_held_valid;      // '|' or '&' waiting for its lookahead byte
    logic [7:0] r_held_byte;
    logic       r_swallow;         // previous byte was an unquoted backslash
    logic       r_seg_has;         // open segment holds at least one byte

    logic       n_sq, n_dq, n_held_valid, n_swallow, n_seg_has;
    logic [7:0] n_held_byte;

    // Results produced by the byte on the input this cycle
    t_result             w_res [MAX_RES];
    logic [RES_IDX_W:0]  w_res_cnt;

    // Result queue
    t_result             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    logic in_xfer, out_xfer;

    // Accept only when the queue can take the worst case of one byte
    assign o_s_axis_tready = (r_count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
    assign in_xfer         = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign out_xfer        = o_m_axis_tvalid & i_m_axis_tready;

    assign o_m_axis_tdata  = r_mem[r_rd_ptr].seg_byte;
    assign o_m_axis_tuser  = r_mem[r_rd_ptr].is_boundary;
    assign o_m_axis_tlast  = r_mem[r_rd_ptr].last;

    // Single-pass parse of one byte: resolve the held operator, classify the
    // byte, then close out the command if this is its final byte.
    always_comb begin
        logic [7:0]         c;
        logic               do_take;
        logic               unq;
        logic [RES_IDX_W:0] k;

        c       = i_s_axis_tdata;
        do_take = 1'b1;
        k       = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            w_res[i] = '0;
        end

        n_sq         = r_sq;
        n_dq         = r_dq;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_swallow    = r_swallow;
        n_seg_has    = r_seg_has;

        // Held operator meets its lookahead
        if (r_held_valid) begin
            if (c == r_held_byte) begin
                // '||' or '&&'
                w_res[k[RES_IDX_W-1:0]].is_boundary = 1'b1;
                n_seg_has = 1'b0;
                k         = k + 1'b1;
                do_take   = 1'b0;
            end else if (r_held_byte == CH_PIPE) begin
                // single pipe
                w_res[k[RES_IDX_W-1:0]].is_boundary = 1'b1;
                n_seg_has = 1'b0;
                k         = k + 1'b1;
            end else begin
                // lone '&' is plain text
                w_res[k[RES_IDX_W-1:0]].seg_byte = r_held_byte;
                n_seg_has = 1'b1;
                k         = k + 1'b1;
            end
            n_held_valid = 1'b0;
            n_held_byte  = '0;
        end

        unq = !n_sq && !n_dq;
        if (do_take) begin
            if (n_swallow) begin
                n_swallow = 1'b0;
                w_res[k[RES_IDX_W-1:0]].seg_byte = c;
                n_seg_has = 1'b1;
                k         = k + 1'b1;
            end else if (unq && c == CH_BSLASH) begin
                n_swallow = 1'b1;
                w_res[k[RES_IDX_W-1:0]].seg_byte = c;
                n_seg_has = 1'b1;
                k         = k + 1'b1;
            end else if (unq && c == CH_SEMI) begin
                w_res[k[RES_IDX_W-1:0]].is_boundary = 1'b1;
                n_seg_has = 1'b0;
                k         = k + 1'b1;
            end else if (unq && (c == CH_PIPE || c == CH_AMP)) begin
                n_held_valid = 1'b1;
                n_held_byte  = c;
            end else begin
                if (c == CH_SQUOTE && !n_dq) begin
                    n_sq = !n_sq;
                end else if (c == CH_DQUOTE && !n_sq) begin
                    n_dq = !n_dq;
                end
                w_res[k[RES_IDX_W-1:0]].seg_byte = c;
                n_seg_has = 1'b1;
                k         = k + 1'b1;
            end
        end

        // Final byte: flush any held operator, close a non-empty segment
        if (i_s_axis_tlast) begin
            if (n_held_valid) begin
                if (n_held_byte == CH_PIPE) begin
                    w_res[k[RES_IDX_W-1:0]].is_boundary = 1'b1;
                    n_seg_has = 1'b0;
                end else begin
                    w_res[k[RES_IDX_W-1:0]].seg_byte = n_held_byte;
                    n_seg_has = 1'b1;
                end
                k = k + 1'b1;
            end
            if (n_seg_has) begin
                w_res[k[RES_IDX_W-1:0]].is_boundary = 1'b1;
                k = k + 1'b1;
            end
            if (k != '0) begin
                w_res[RES_IDX_W'(k - 1'b1)].last = 1'b1;
            end
            // next byte starts a fresh command
            n_sq         = 1'b0;
            n_dq         = 1'b0;
            n_held_valid = 1'b0;
            n_held_byte  = '0;
            n_swallow    = 1'b0;
            n_seg_has    = 1'b0;
        end

        w_res_cnt = k;
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq         <= 1'b0;
            r_dq         <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
            r_swallow    <= 1'b0;
            r_seg_has    <= 1'b0;
        end else if (in_xfer) begin
            r_sq         <= n_sq;
            r_dq         <= n_dq;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_swallow    <= n_swallow;
            r_seg_has    <= n_seg_has;
        end
    end

    // Queue storage: up to MAX_RES entries written per transaction
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (w_res_cnt > (RES_IDX_W + 1)'(i)) begin
                    r_mem[r_wr_ptr + Q_PTR_W'(i)] <= w_res[i];
                end
            end
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_xfer) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(w_res_cnt);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (in_xfer ? Q_CNT_W'(w_res_cnt) : '0)
                               - Q_CNT_W'(out_xfer);
        end
    end

    // Queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // Boundary markers carry a zero byte
    a_boundary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 8'h00))
        else $error("boundary result with nonzero byte");

    // Final byte of a command leaves the parser in its reset state
    a_eoc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_axis_tlast) |=>
        (!r_sq && !r_dq && !r_held_valid && !r_swallow && !r_seg_has))
        else $error("parser state not cleared after end of command");

    // Nothing is held unless it is a pipe or an ampersand
    a_held_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_held_byte == CH_PIPE || r_held_byte == CH_AMP))
        else $error("held byte is not an operator");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import qacs_pkg::*;

    // One command byte waiting to be offered on the input stream
    typedef struct {
        logic [7:0] ch;
        logic       eoc;
        int         gap;    // idle cycles before the byte is offered
        bit         drain;  // hold the byte back until every result has come
    } t_cmd_item;

    localparam int HOLD_CYCLES = 60;   // long receiver hold-off
    localparam int TAIL_CYCLES = 8;    // settle time after the last result

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] cmd_byte
    logic       i_s_axis_tlast = 1'b0;    // end_of_command
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] seg_byte
    logic       o_m_axis_tuser;           // [0] is_boundary
    logic       o_m_axis_tlast;           // last result of the final command byte

    quote_aware_command_splitter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Splitter state as the testbench tracks it
    // ------------------------------------------------------------------
    logic       sq_open = 1'b0;
    logic       dq_open = 1'b0;
    logic       escape_pending = 1'b0;   // previous byte was an unquoted backslash
    logic       held_vld = 1'b0;         // '|' or '&' waiting for its neighbor
    logic [7:0] held_ch = 8'h00;
    logic       seg_nonempty = 1'b0;

    t_result    step_res [MAX_RES];      // results of the byte being split
    int         step_n;
    t_result    seg_expect [$];          // results still owed by the block

    t_cmd_item  cmd_stream [$];
    int         n_items = 0;
    int         bytes_taken = 0;
    int         hold_at = 32'h7fffffff;
    int         tx_wait = 0;
    int         rx_wait = 0;
    int         rx_draw;
    bit         rx_calm = 1'b0;
    bit         rx_hold = 1'b0;
    int         fail_cnt = 0;
    t_result    got;
    t_result    want;

    task automatic emit_res(input logic [7:0] b, input logic boundary);
        step_res[step_n].seg_byte    = boundary ? 8'h00 : b;
        step_res[step_n].is_boundary = boundary;
        step_res[step_n].last        = 1'b0;
        seg_nonempty = !boundary;
        step_n++;
    endtask

    // Byte handling with nothing held back
    task automatic scan_plain(input logic [7:0] c);
        logic quoted;
        quoted = sq_open || dq_open;
        if (escape_pending) begin
            escape_pending = 1'b0;
            emit_res(c, 1'b0);
        end else if (!quoted && c == CH_BSLASH) begin
            escape_pending = 1'b1;
            emit_res(c, 1'b0);
        end else if (!quoted && c == CH_SEMI) begin
            emit_res(8'h00, 1'b1);
        end else if (!quoted && (c == CH_PIPE || c == CH_AMP)) begin
            held_ch  = c;
            held_vld = 1'b1;
        end else begin
            // a quote toggles only when not inside the other kind
            if (c == CH_SQUOTE && !dq_open)
                sq_open = !sq_open;
            else if (c == CH_DQUOTE && !sq_open)
                dq_open = !dq_open;
            emit_res(c, 1'b0);
        end
    endtask

    // Work out every result one accepted byte causes and queue them
    task automatic split_byte(input logic [7:0] c, input logic eoc);
        logic [7:0] h;
        step_n = 0;
        if (held_vld) begin
            h = held_ch;
            held_vld = 1'b0;
            held_ch  = 8'h00;
            if (c == h) begin
                emit_res(8'h00, 1'b1);          // doubled operator
            end else begin
                if (h == CH_PIPE)
                    emit_res(8'h00, 1'b1);      // single pipe
                else
                    emit_res(h, 1'b0);          // lone ampersand is plain text
                scan_plain(c);
            end
        end else begin
            scan_plain(c);
        end
        if (eoc) begin
            // flush a pending operator, close a non-empty segment, start over
            if (held_vld) begin
                if (held_ch == CH_PIPE)
                    emit_res(8'h00, 1'b1);
                else
                    emit_res(held_ch, 1'b0);
            end
            if (seg_nonempty)
                emit_res(8'h00, 1'b1);
            sq_open = 1'b0;
            dq_open = 1'b0;
            escape_pending = 1'b0;
            held_vld = 1'b0;
            held_ch = 8'h00;
            seg_nonempty = 1'b0;
            if (step_n > 0)
                step_res[step_n - 1].last = 1'b1;
        end
        for (int k = 0; k < step_n; k++)
            seg_expect = {seg_expect, step_res[k]};
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int item_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic add_item(input logic [7:0] c, input logic eoc, input int gap,
                            input bit drain);
        t_cmd_item it;
        it.ch    = c;
        it.eoc   = eoc;
        it.gap   = gap;
        it.drain = drain;
        cmd_stream = {cmd_stream, it};
        n_items++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], i == s.len() - 1, item_gap(1'b0), 1'b0);
    endtask

    // Mostly shell-ish text with the interesting characters weighted up;
    // a fully random byte now and then as noise.
    function automatic logic [7:0] pick_cmd_char();
        case ($urandom_range(0, 15))
            0:       return CH_SEMI;
            1, 2:    return CH_PIPE;
            3, 4:    return CH_AMP;
            5:       return CH_BSLASH;
            6:       return CH_SQUOTE;
            7:       return CH_DQUOTE;
            8:       return 8'($urandom_range(0, 255));
            9:       return 8'h20;
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, predicts on every accepted transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                split_byte(i_s_axis_tdata, i_s_axis_tlast);
                bytes_taken <= bytes_taken + 1;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cmd_stream.size() == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                end else if (cmd_stream[0].drain && seg_expect.size() != 0) begin
                    // pause until the block has handed back everything owed
                    i_s_axis_tvalid <= 1'b0;
                end else if (tx_wait < cmd_stream[0].gap) begin
                    tx_wait <= tx_wait + 1;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= cmd_stream[0].ch;
                    i_s_axis_tlast  <= cmd_stream[0].eoc;
                    void'(cmd_stream.pop_front());
                    tx_wait <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest expectation
    // and throttles tready with random stalls, calm stretches and a hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.seg_byte    = o_m_axis_tdata;
                got.is_boundary = o_m_axis_tuser;
                got.last        = o_m_axis_tlast;
                if (seg_expect.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: byte %02h bnd %0b last %0b",
                                 got.seg_byte, got.is_boundary, got.last);
                end else begin
                    want = seg_expect.pop_front();
                    if (got.seg_byte !== want.seg_byte
                            || got.is_boundary !== want.is_boundary
                            || got.last !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     want.seg_byte, want.is_boundary, want.last,
                                     got.seg_byte, got.is_boundary, got.last);
                    end
                end
                rx_draw = rx_calm ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
                rx_wait <= rx_draw;
                i_m_axis_tready <= (rx_draw == 0) && !rx_hold;
            end else if (rx_hold) begin
                i_m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                i_m_axis_tready <= (rx_wait == 1);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps streaming, so the result
    // queue fills and input tready drops.
    initial begin
        while (bytes_taken < hold_at)
            @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int  len;
        int  burst_left;
        bit  calm;
        logic [7:0] c;

        // Directed commands
        add_text(";");                  // separator on an empty segment
        add_text("a||b");               // doubled pipe
        add_text("x&&|");               // doubled ampersand, pipe held at end
        add_text("\\;&");               // escaped separator, ampersand held at end
        add_text("'|'\"");              // pipe inside quotes, unterminated quote
        add_text("\"'\"\\");            // quote inside other quote, trailing backslash
        add_item(8'h00, 1'b0, item_gap(1'b0), 1'b0);
        add_item(8'hFF, 1'b0, item_gap(1'b0), 1'b0);
        add_text("|&");                 // single pipe, then lone ampersand at end

        // Random commands
        burst_left = 0;
        while (n_items < 310) begin
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(1, 12);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                if (hold_at == 32'h7fffffff && n_items >= 150) begin
                    hold_at = n_items;
                    burst_left = 40;
                end
                c = pick_cmd_char();
                add_item(c, k == len - 1,
                         (burst_left > 0) ? 0 : item_gap(calm),
                         n_items == 24 || n_items == 250);
                if (burst_left > 0)
                    burst_left--;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_stream.size() != 0 || i_s_axis_tvalid || seg_expect.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (seg_expect.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/qacs_pkg.sv
src/quote_aware_command_splitter_core.sv
tb/tb.sv
